>>> hdl/scp_pkg.sv
// Shared types, constants and helper functions of the strip cluster position finder.
// No dependencies; every other file of the block but scp_ram imports this package.
`default_nettype none
package scp_pkg;

   // Field widths and sizing defaults.
   localparam int HIT_DEPTH_DEF = 32;
   localparam int CHAN_W        = 9;
   localparam int CHG_W         = 16;
   localparam int HITS_W        = 6;
   localparam int POS_W         = 10;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 9;
   localparam int CHAN_MAX      = 511;
   localparam int HIT_W         = CHAN_W + CHG_W;
   localparam int CMP_W         = 8;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRONT_FIRST = 3'd0,
      CSR_FRONT_LAST  = 3'd1,
      CSR_BACK_FIRST  = 3'd2,
      CSR_BACK_LAST   = 3'd3,
      CSR_MIN_HITS    = 3'd4,
      CSR_MAX_HITS    = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [CHAN_W-1:0] front_first;
      logic [CHAN_W-1:0] front_last;
      logic [CHAN_W-1:0] back_first;
      logic [CHAN_W-1:0] back_last;
      logic [HITS_W-1:0] min_hits;
      logic [HITS_W-1:0] max_hits;
   } cfg_type;

   // One classified hit as it travels from the front part to the back part.
   typedef struct packed {
      logic [CHAN_W-1:0] chan;
      logic [CHG_W-1:0]  chg;
      logic              in_front;
      logic              in_back;
      logic              last;
   } qitem_type;

   // Strobes from the back sequencer to both side lanes.
   typedef struct packed {
      logic clear;
      logic lat_i;
      logic end_i;
      logic jv;
      logic pass2;
      logic init_p2;
      logic div_load;
      logic div_step;
   } ctrl_type;

   typedef enum logic [3:0] {
      S_LOAD, S_EVAL, S_IADDR, S_ILAT, S_JSCAN, S_JDRAIN,
      S_P2INIT, S_P2SCAN, S_P2DRAIN, S_DLOAD, S_DIV, S_DONE
   } state_type;

   // Ranking order: charge descending, then channel descending, then store order.
   function automatic logic ranks_above(input logic [CHG_W-1:0] ac, input logic [CHAN_W-1:0] an,
                                        input logic [CHG_W-1:0] bc, input logic [CHAN_W-1:0] bn,
                                        input logic idx_lt);
      logic r;
      if (ac != bc) begin
         r = ac > bc;
      end else if (an != bn) begin
         r = an > bn;
      end else begin
         r = idx_lt;
      end
      return r;
   endfunction

   // Two channels are neighbors when they differ by zero or one.
   function automatic logic is_neighbor(input logic [CHAN_W-1:0] a, input logic [CHAN_W-1:0] b);
      logic [CHAN_W-1:0] d;
      d = (a > b) ? (a - b) : (b - a);
      return d < CHAN_W'(2);
   endfunction

endpackage
`default_nettype wire

>>> hdl/scp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module scp_ram #(
   parameter int WIDTH = 25,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

>>> hdl/scp_front.sv
// Front part: configuration registers and classification of incoming hits.
// Depends on scp_pkg.
`default_nettype none
module scp_front import scp_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [CHAN_W-1:0]     req_channel,
   input  wire logic [CHG_W-1:0]      req_charge,
   input  wire logic                  req_event_end,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                  q_full,
   output logic                       q_push,
   output qitem_type                  q_item,
   output cfg_type                    cfg
);
   cfg_type cfg_ff, cfg_in;

   // Register writes; indexes beyond the list are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FRONT_FIRST: cfg_in.front_first = csr_wdata;
            CSR_FRONT_LAST:  cfg_in.front_last  = csr_wdata;
            CSR_BACK_FIRST:  cfg_in.back_first  = csr_wdata;
            CSR_BACK_LAST:   cfg_in.back_last   = csr_wdata;
            CSR_MIN_HITS:    cfg_in.min_hits    = csr_wdata[HITS_W-1:0];
            CSR_MAX_HITS:    cfg_in.max_hits    = csr_wdata[HITS_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{front_first: 9'd0, front_last: 9'd39, back_first: 9'd80,
                     back_last: 9'd119, min_hits: 6'd2, max_hits: 6'd20};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Classify each beat against both strip ranges and push it to the queue.
   always_comb begin
      q_item.chan     = req_channel;
      q_item.chg      = req_charge;
      q_item.in_front = (req_channel >= cfg_ff.front_first) && (req_channel <= cfg_ff.front_last);
      q_item.in_back  = (req_channel >= cfg_ff.back_first) && (req_channel <= cfg_ff.back_last);
      q_item.last     = req_event_end;
   end

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;
   assign cfg       = cfg_ff;
endmodule
`default_nettype wire

>>> hdl/scp_queue.sv
// Four-entry queue that decouples the front and back parts.
// Depends on scp_pkg.
`default_nettype none
module scp_queue import scp_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  qitem_type push_item,
   output logic      full,
   input  wire logic pop,
   output qitem_type pop_item,
   output logic      empty
);
   localparam int QD = 4;
   localparam int PW = $clog2(QD);

   qitem_type        slot_ff [QD];
   logic [PW-1:0]    wptr_ff, rptr_ff;
   logic [PW:0]      count_ff, count_in;

   assign full     = count_ff == (PW+1)'(QD);
   assign empty    = count_ff == '0;
   assign pop_item = slot_ff[rptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wptr_ff <= wptr_ff + 1'b1;
         end
         if (pop) begin
            rptr_ff <= rptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= push_item;
      end
   end
endmodule
`default_nettype wire

>>> hdl/scp_lane.sv
// One side lane: hit store, seed search, cluster sum and radix-2 divider.
// Depends on scp_pkg and scp_ram.
`default_nettype none
module scp_lane import scp_pkg::*; #(
   parameter int HIT_DEPTH = HIT_DEPTH_DEF
) (
   input  wire logic                         clock,
   input  ctrl_type                          ctrl,
   input  wire logic                         we,
   input  wire logic [$clog2(HIT_DEPTH)-1:0] waddr,
   input  wire logic [CHAN_W-1:0]            wchan,
   input  wire logic [CHG_W-1:0]             wchg,
   input  wire logic [$clog2(HIT_DEPTH)-1:0] raddr,
   input  wire logic [$clog2(HIT_DEPTH)-1:0] i_idx,
   input  wire logic [$clog2(HIT_DEPTH)-1:0] jd_idx,
   input  wire logic [$clog2(HIT_DEPTH+2)-1:0] n,
   input  wire logic [CHAN_W-1:0]            first,
   output logic      [POS_W-1:0]             position
);
   localparam int AW = $clog2(HIT_DEPTH);
   localparam int TW = $clog2(HIT_DEPTH + 2);
   localparam int SW = $clog2(HIT_DEPTH * CHAN_MAX + 1);
   localparam int CW = $clog2(HIT_DEPTH + 1);

   logic [HIT_W-1:0]  rdata;
   logic [CHAN_W-1:0] e_chan;
   logic [CHG_W-1:0]  e_chg;

   logic [CHAN_W-1:0] cur_chan_ff;
   logic [CHG_W-1:0]  cur_chg_ff;
   logic              seeded_ff;
   logic [CHAN_W-1:0] best_chan_ff;
   logic [CHG_W-1:0]  best_chg_ff;
   logic [AW-1:0]     best_i_ff;
   logic              best_v_ff;
   logic [SW-1:0]     sum_ff;
   logic [CW-1:0]     cnt_ff;
   logic [SW-1:0]     quo_ff;
   logic [CW-1:0]     rem_ff;

   logic              i_ok, j_ok, hit_now, seeded_now, take_best, join_now;
   logic [CHG_W-1:0]  diff;
   logic [19:0]       tenx;
   logic [CW:0]       trial;
   logic              q_bit;

   scp_ram #(.WIDTH(HIT_W), .DEPTH(HIT_DEPTH)) u_store (
      .clock(clock), .we(we), .waddr(waddr), .wdata({wchan, wchg}),
      .raddr(raddr), .rdata(rdata)
   );

   assign e_chan = rdata[HIT_W-1:CHG_W];
   assign e_chg  = rdata[CHG_W-1:0];

   // Seed search: does the held hit have a lower-ranked neighbor?
   always_comb begin
      i_ok       = TW'(i_idx) < n;
      j_ok       = TW'(jd_idx) < n;
      hit_now    = ctrl.jv && !ctrl.pass2 && i_ok && j_ok &&
                   ranks_above(cur_chg_ff, cur_chan_ff, e_chg, e_chan, i_idx < jd_idx) &&
                   is_neighbor(cur_chan_ff, e_chan);
      seeded_now = seeded_ff || hit_now;
      take_best  = seeded_now && (!best_v_ff ||
                   ranks_above(cur_chg_ff, cur_chan_ff, best_chg_ff, best_chan_ff,
                               i_idx < best_i_ff));
   end

   // Cluster membership: lower-ranked neighbor within a tenth of the seed charge.
   always_comb begin
      diff     = best_chg_ff - e_chg;
      tenx     = ({4'b0, diff} << 3) + ({4'b0, diff} << 1);
      join_now = ctrl.jv && ctrl.pass2 && j_ok && best_v_ff &&
                 ranks_above(best_chg_ff, best_chan_ff, e_chg, e_chan, best_i_ff < jd_idx) &&
                 is_neighbor(best_chan_ff, e_chan) && (tenx < 20'(best_chg_ff));
   end

   // One quotient bit per step.
   always_comb begin
      trial = {rem_ff, quo_ff[SW-1]};
      q_bit = trial >= (CW+1)'(cnt_ff);
   end

   always_ff @(posedge clock) begin
      if (ctrl.lat_i) begin
         cur_chan_ff <= e_chan;
         cur_chg_ff  <= e_chg;
         seeded_ff   <= 1'b0;
      end else if (ctrl.jv && !ctrl.pass2) begin
         seeded_ff <= seeded_now;
      end
      if (ctrl.clear) begin
         best_v_ff <= 1'b0;
      end else if (ctrl.end_i && take_best) begin
         best_v_ff    <= 1'b1;
         best_chan_ff <= cur_chan_ff;
         best_chg_ff  <= cur_chg_ff;
         best_i_ff    <= i_idx;
      end
      if (ctrl.init_p2) begin
         sum_ff <= best_v_ff ? SW'(best_chan_ff) : '0;
         cnt_ff <= best_v_ff ? CW'(1) : '0;
      end else if (join_now) begin
         sum_ff <= sum_ff + SW'(e_chan);
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (ctrl.div_load) begin
         quo_ff <= sum_ff;
         rem_ff <= '0;
      end else if (ctrl.div_step) begin
         quo_ff <= {quo_ff[SW-2:0], q_bit};
         rem_ff <= q_bit ? CW'(trial - (CW+1)'(cnt_ff)) : trial[CW-1:0];
      end
   end

   assign position = (cnt_ff == '0) ? '1 : (quo_ff[POS_W-1:0] - {1'b0, first});
endmodule
`default_nettype wire

>>> hdl/scp_back.sv
// Back part: store writes, hit tallies, evaluation sequencer and result register.
// Depends on scp_pkg and scp_lane.
`default_nettype none
module scp_back import scp_pkg::*; #(
   parameter int HIT_DEPTH = HIT_DEPTH_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  cfg_type                 cfg,
   input  qitem_type               q_item,
   input  wire logic               q_empty,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [POS_W-1:0] rsp_front_position,
   output logic signed [POS_W-1:0] rsp_back_position
);
   localparam int AW = $clog2(HIT_DEPTH);
   localparam int TW = $clog2(HIT_DEPTH + 2);
   localparam int SW = $clog2(HIT_DEPTH * CHAN_MAX + 1);
   localparam int DW = $clog2(SW);

   state_type        state_ff, state_in;
   logic [TW-1:0]    ftally_ff, btally_ff, nmax;
   logic [AW-1:0]    i_ff, j_ff, jd_ff, raddr;
   logic             jv_ff, force_ff, bad;
   logic [DW-1:0]    dcnt_ff;
   logic             rsp_valid_ff, rsp_load;
   logic [POS_W-1:0] rsp_front_ff, rsp_back_ff, fpos, bpos;
   logic             f_we, b_we;
   ctrl_type         ctrl;

   // Side checks against the hit bounds.
   always_comb begin
      bad = (CMP_W'(ftally_ff) < CMP_W'(cfg.min_hits)) ||
            (CMP_W'(btally_ff) < CMP_W'(cfg.min_hits)) ||
            (CMP_W'(ftally_ff) > CMP_W'(cfg.max_hits)) ||
            (CMP_W'(btally_ff) > CMP_W'(cfg.max_hits)) ||
            (ftally_ff > TW'(HIT_DEPTH)) || (btally_ff > TW'(HIT_DEPTH));
      nmax = (ftally_ff > btally_ff) ? ftally_ff : btally_ff;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_LOAD:    if (!q_empty && q_item.last) state_in = S_EVAL;
         S_EVAL:    if (bad) state_in = S_DONE;
                    else if (nmax == '0) state_in = S_P2INIT;
                    else state_in = S_IADDR;
         S_IADDR:   state_in = S_ILAT;
         S_ILAT:    state_in = S_JSCAN;
         S_JSCAN:   if (TW'(j_ff) == nmax - 1'b1) state_in = S_JDRAIN;
         S_JDRAIN:  state_in = (TW'(i_ff) == nmax - 1'b1) ? S_P2INIT : S_IADDR;
         S_P2INIT:  state_in = (nmax == '0) ? S_DLOAD : S_P2SCAN;
         S_P2SCAN:  if (TW'(j_ff) == nmax - 1'b1) state_in = S_P2DRAIN;
         S_P2DRAIN: state_in = S_DLOAD;
         S_DLOAD:   state_in = S_DIV;
         S_DIV:     if (dcnt_ff == DW'(SW - 1)) state_in = S_DONE;
         S_DONE:    if (!rsp_valid_ff || !rsp_stall) state_in = S_LOAD;
         default:   state_in = S_LOAD;
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      q_pop         = 1'b0;
      raddr         = i_ff;
      ctrl          = '0;
      ctrl.jv       = jv_ff;
      rsp_load      = 1'b0;
      case (state_ff)
         S_LOAD:    q_pop = !q_empty;
         S_EVAL:    ctrl.clear = 1'b1;
         S_IADDR:   raddr = i_ff;
         S_ILAT:    ctrl.lat_i = 1'b1;
         S_JSCAN:   raddr = j_ff;
         S_JDRAIN:  ctrl.end_i = 1'b1;
         S_P2INIT:  ctrl.init_p2 = 1'b1;
         S_P2SCAN:  begin
            raddr      = j_ff;
            ctrl.pass2 = 1'b1;
         end
         S_P2DRAIN: ctrl.pass2 = 1'b1;
         S_DLOAD:   ctrl.div_load = 1'b1;
         S_DIV:     ctrl.div_step = 1'b1;
         S_DONE:    rsp_load = !rsp_valid_ff || !rsp_stall;
         default:   q_pop = 1'b0;
      endcase
      f_we = q_pop && q_item.in_front && (ftally_ff < TW'(HIT_DEPTH));
      b_we = q_pop && q_item.in_back && (btally_ff < TW'(HIT_DEPTH));
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         ftally_ff    <= '0;
         btally_ff    <= '0;
         jv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         jv_ff    <= (state_ff == S_JSCAN) || (state_ff == S_P2SCAN);
         if (q_pop && q_item.in_front && (ftally_ff <= TW'(HIT_DEPTH))) begin
            ftally_ff <= ftally_ff + 1'b1;
         end
         if (q_pop && q_item.in_back && (btally_ff <= TW'(HIT_DEPTH))) begin
            btally_ff <= btally_ff + 1'b1;
         end
         if (state_ff == S_EVAL) begin
            ftally_ff <= ftally_ff;
            btally_ff <= btally_ff;
         end
         if (rsp_load) begin
            ftally_ff    <= '0;
            btally_ff    <= '0;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Scan and divider counters.
   always_ff @(posedge clock) begin
      jd_ff <= j_ff;
      case (state_ff)
         S_EVAL:    begin
            force_ff <= bad;
            i_ff     <= '0;
         end
         S_ILAT:    j_ff <= '0;
         S_JSCAN:   j_ff <= j_ff + 1'b1;
         S_JDRAIN:  i_ff <= i_ff + 1'b1;
         S_P2INIT:  j_ff <= '0;
         S_P2SCAN:  j_ff <= j_ff + 1'b1;
         S_DLOAD:   dcnt_ff <= '0;
         S_DIV:     dcnt_ff <= dcnt_ff + 1'b1;
         default:   dcnt_ff <= dcnt_ff;
      endcase
   end

   scp_lane #(.HIT_DEPTH(HIT_DEPTH)) u_front_lane (
      .clock(clock), .ctrl(ctrl), .we(f_we), .waddr(ftally_ff[AW-1:0]),
      .wchan(q_item.chan), .wchg(q_item.chg), .raddr(raddr), .i_idx(i_ff),
      .jd_idx(jd_ff), .n(ftally_ff), .first(cfg.front_first), .position(fpos)
   );

   scp_lane #(.HIT_DEPTH(HIT_DEPTH)) u_back_lane (
      .clock(clock), .ctrl(ctrl), .we(b_we), .waddr(btally_ff[AW-1:0]),
      .wchan(q_item.chan), .wchg(q_item.chg), .raddr(raddr), .i_idx(i_ff),
      .jd_idx(jd_ff), .n(btally_ff), .first(cfg.back_first), .position(bpos)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_front_ff <= force_ff ? '1 : fpos;
         rsp_back_ff  <= force_ff ? '1 : bpos;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_front_position = rsp_front_ff;
   assign rsp_back_position  = rsp_back_ff;
endmodule
`default_nettype wire

>>> hdl/strip_cluster_position_finder_core.sv
// Throughput: one hit per cycle loads through a four-beat queue while the back part is loading;
// during evaluation the queue fills and req_stall holds the input. Pairwise scans and the
// divider set the per-event time.
// Reset is synchronous and active high; it clears tallies, queue and sequencer and sets the configuration
// registers to their defaults. The hit stores are not cleared.
`default_nettype none
module strip_cluster_position_finder_core import scp_pkg::*; #(
   parameter int HIT_DEPTH = HIT_DEPTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [CHAN_W-1:0]     req_channel,
   input  wire logic [CHG_W-1:0]      req_charge,
   input  wire logic                  req_event_end,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic signed [POS_W-1:0]    rsp_front_position,
   output logic signed [POS_W-1:0]    rsp_back_position,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);
   cfg_type   cfg;
   qitem_type push_item, pop_item;
   logic      q_push, q_full, q_pop, q_empty;

   scp_front u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_channel(req_channel), .req_charge(req_charge), .req_event_end(req_event_end),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .q_full(q_full), .q_push(q_push), .q_item(push_item), .cfg(cfg)
   );

   scp_queue u_queue (
      .clock(clock), .reset(reset), .push(q_push), .push_item(push_item), .full(q_full),
      .pop(q_pop), .pop_item(pop_item), .empty(q_empty)
   );

   scp_back #(.HIT_DEPTH(HIT_DEPTH)) u_back (
      .clock(clock), .reset(reset), .cfg(cfg), .q_item(pop_item), .q_empty(q_empty),
      .q_pop(q_pop), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_front_position(rsp_front_position), .rsp_back_position(rsp_back_position)
   );
endmodule
`default_nettype wire

>>> hdl/scp_checker.sv
// Port-level checker of the strip cluster position finder, bound to the top level.
// Depends on scp_pkg and strip_cluster_position_finder_core.
`default_nettype none
module scp_checker import scp_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_stall,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire logic [POS_W-1:0]  rsp_front_position,
   input wire logic [POS_W-1:0]  rsp_back_position
);
   // A stalled result beat holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_front_position) &&
      $stable(rsp_back_position))
      else $error("result beat changed while stalled");

   // After reset no result is pending and the input side is open.
   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

   // A result needs at least a hit, a queue pass and an evaluation after reset.
   a_no_early_rsp: assert property (@(posedge clock)
      $rose(rsp_valid) |-> !$past(reset) && !$past(reset, 2))
      else $error("result appeared too soon after reset");
endmodule

bind strip_cluster_position_finder_core scp_checker u_scp_checker (
   .clock(clock), .reset(reset), .req_stall(req_stall), .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall), .rsp_front_position(rsp_front_position),
   .rsp_back_position(rsp_back_position)
);
`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench for the strip cluster position finder core.
// Depends on scp_pkg and strip_cluster_position_finder_core; holds its own position predictor.
`default_nettype none
module testbench;
   import scp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = 32;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam logic [POS_W-1:0] NO_POSITION = '1;

   typedef struct packed {
      logic [CHAN_W-1:0] chan;
      logic [CHG_W-1:0]  chg;
   } hit_type;

   typedef struct packed {
      logic [POS_W-1:0] front_pos;
      logic [POS_W-1:0] back_pos;
   } position_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [CHAN_W-1:0] req_channel = '0;
   logic [CHG_W-1:0] req_charge = '0;
   logic req_event_end = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [POS_W-1:0] rsp_front_position;
   logic signed [POS_W-1:0] rsp_back_position;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Predictor state: configuration copy, per-side stores and tallies.
   logic [CHAN_W-1:0] front_first, front_last, back_first, back_last;
   logic [HITS_W-1:0] min_hits, max_hits;
   hit_type front_hits[DEPTH];
   hit_type back_hits[DEPTH];
   int front_count, back_count;

   position_type expected_positions[$];
   int failures = 0;
   int idle_pct = 36;
   bit rx_hold = 1'b0;
   int idle_cycles = 0;

   always #6 clock = ~clock;

   strip_cluster_position_finder_core dut (.*);

   // Hit is placed in a side store; the tally saturates one past the depth.
   function automatic void store_hit(ref hit_type st[DEPTH], ref int cnt,
                                     input hit_type h);
      if (cnt < DEPTH) st[cnt] = h;
      if (cnt <= DEPTH) cnt++;
   endfunction

   function automatic bit outranks(hit_type a, hit_type b);
      if (a.chg != b.chg) return a.chg > b.chg;
      return a.chan > b.chan;
   endfunction

   // Sort by rank, find the seed, average it with its close-charge neighbors.
   function automatic logic [POS_W-1:0] cluster_position(hit_type st[DEPTH], int n,
                                                          logic [CHAN_W-1:0] first);
      hit_type v[DEPTH];
      hit_type t;
      int j;
      int unsigned sum, cnt, d;
      logic [31:0] diff;
      bit seeded;
      sum = 0;
      cnt = 0;
      if (n > DEPTH) n = DEPTH;
      for (int i = 0; i < n; i++) v[i] = st[i];
      for (int i = 1; i < n; i++) begin
         t = v[i];
         j = i;
         while (j > 0 && outranks(t, v[j-1])) begin
            v[j] = v[j-1];
            j--;
         end
         v[j] = t;
      end
      for (int i = 0; i < n; i++) begin
         seeded = 1'b0;
         for (int k = i + 1; k < n; k++) begin
            d = (v[i].chan > v[k].chan) ? v[i].chan - v[k].chan : v[k].chan - v[i].chan;
            if (d < 2) begin
               seeded = 1'b1;
               diff = 32'(v[i].chg) - 32'(v[k].chg);
               if (32'(10 * diff) < 32'(v[i].chg)) begin
                  sum += v[k].chan;
                  cnt++;
               end
            end
         end
         if (seeded) begin
            sum += v[i].chan;
            cnt++;
            break;
         end
      end
      if (cnt == 0) return NO_POSITION;
      return POS_W'(sum / cnt - first);
   endfunction

   // Accounts for one accepted hit beat and queues the result it causes.
   function automatic void predict_hit(logic [CHAN_W-1:0] chan, logic [CHG_W-1:0] chg,
                                       logic last);
      position_type p;
      hit_type h;
      h = '{chan, chg};
      if (chan >= front_first && chan <= front_last) store_hit(front_hits, front_count, h);
      if (chan >= back_first && chan <= back_last) store_hit(back_hits, back_count, h);
      if (!last) return;
      if (front_count < min_hits || back_count < min_hits || front_count > max_hits ||
          back_count > max_hits || front_count > DEPTH || back_count > DEPTH) begin
         p = '{NO_POSITION, NO_POSITION};
      end else begin
         p.front_pos = cluster_position(front_hits, front_count, front_first);
         p.back_pos = cluster_position(back_hits, back_count, back_first);
      end
      expected_positions.insert(expected_positions.size(), p);
      front_count = 0;
      back_count = 0;
   endfunction

   // Result checker: each accepted beat is compared with the oldest prediction.
   always @(posedge clock) begin
      position_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_positions.size() == 0) begin
            $error("unexpected result beat front=%0d back=%0d",
                   rsp_front_position, rsp_back_position);
            failures++;
         end else begin
            e = expected_positions.pop_front();
            if (rsp_front_position !== e.front_pos) begin
               $error("front_position expected %0d actual %0d",
                      $signed(e.front_pos), rsp_front_position);
               failures++;
            end
            if (rsp_back_position !== e.back_pos) begin
               $error("back_position expected %0d actual %0d",
                      $signed(e.back_pos), rsp_back_position);
               failures++;
            end
         end
      end
   end

   // Receiver stall: random, or held off completely while rx_hold is set.
   always @(posedge clock) begin
      rsp_stall <= rx_hold || ($urandom_range(99) < idle_pct);
   end

   // Watchdog on cycles without any accepted beat.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Sends one hit beat, with a random gap before it.
   task automatic send_hit(int chan, int chg, int last);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_channel <= CHAN_W'(chan);
      req_charge <= CHG_W'(chg);
      req_event_end <= (last != 0);
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_hit(CHAN_W'(chan), CHG_W'(chg), last != 0);
   endtask

   task automatic release_req();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Waits until every result is in, then for the worst-case event latency.
   task automatic drain();
      release_req();
      while (expected_positions.size() != 0) @(posedge clock);
      repeat (1300) @(posedge clock);
   endtask

   // One register write beat; the caller drops the write enable afterwards.
   task automatic write_reg(csr_index_type idx, int value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      @(posedge clock);
      case (idx)
         CSR_FRONT_FIRST: front_first = CHAN_W'(value);
         CSR_FRONT_LAST:  front_last = CHAN_W'(value);
         CSR_BACK_FIRST:  back_first = CHAN_W'(value);
         CSR_BACK_LAST:   back_last = CHAN_W'(value);
         CSR_MIN_HITS:    min_hits = HITS_W'(value);
         CSR_MAX_HITS:    max_hits = HITS_W'(value);
         default:         ;
      endcase
   endtask

   task automatic set_ranges(int ff, int fl, int bf, int bl, int mn, int mx);
      write_reg(CSR_FRONT_FIRST, ff);
      write_reg(CSR_FRONT_LAST, fl);
      write_reg(CSR_BACK_FIRST, bf);
      write_reg(CSR_BACK_LAST, bl);
      write_reg(CSR_MIN_HITS, mn);
      write_reg(CSR_MAX_HITS, mx);
      csr_we <= 1'b0;
   endtask

   // Sends an event with a cluster on each side plus a few stray hits.
   task automatic send_cluster_event(int nf, int nb);
      int c0, c1, base;
      c0 = $urandom_range(front_first, front_last);
      c1 = $urandom_range(back_first, back_last);
      base = $urandom_range(65535);
      for (int i = 0; i < nf + nb; i++) begin
         int ch;
         int q;
         if (i < nf) ch = c0 + $urandom_range(2) - 1;
         else ch = c1 + $urandom_range(2) - 1;
         if ($urandom_range(7) == 0) ch = $urandom_range(511);
         if (ch < 0) ch = 0;
         if (ch > 511) ch = 511;
         q = base - $urandom_range(base / 6);
         if ($urandom_range(9) == 0) q = $urandom_range(65535);
         send_hit(ch, q, i == nf + nb - 1);
      end
   endtask

   // Directed: field extremes, ties, no seed, out-of-bounds counts.
   task automatic test_directed();
      send_hit(0, 16'hFFFF, 0);
      send_hit(1, 16'hFFFF, 0);
      send_hit(80, 100, 0);
      send_hit(80, 100, 0);
      send_hit(81, 95, 1);
      send_hit(5, 1000, 0);
      send_hit(20, 900, 0);
      send_hit(100, 0, 0);
      send_hit(102, 0, 1);
      send_hit(3, 50, 1);
      send_hit(511, 16'h5555, 0);
      send_hit(10, 16'hAAAA, 0);
      send_hit(11, 16'hAAAA, 0);
      send_hit(119, 0, 0);
      send_hit(118, 16'hFFFF, 1);
      send_hit(256, 7, 1);
      drain();
   endtask

   // Registers at extremes: overlapping full ranges, empty ranges, min/max limits.
   task automatic test_config_extremes();
      set_ranges(0, 511, 0, 511, 0, 32);
      for (int i = 0; i < 20; i++) send_cluster_event($urandom_range(1, 6), 0);
      send_hit(0, 0, 1);
      drain();
      set_ranges(511, 0, 300, 200, 0, 0);
      send_hit(5, 5, 1);
      send_hit(511, 5, 1);
      drain();
      set_ranges(0, 511, 500, 511, 32, 32);
      for (int i = 0; i < 34; i++) send_hit(i % 2 ? 511 : 510, $urandom, i == 33);
      drain();
      set_ranges(400, 511, 0, 100, 1, 63);
      for (int i = 0; i < 40; i++) send_hit($urandom_range(400, 411), $urandom, i == 39);
      send_hit(450, 1, 1);
      drain();
   endtask

   // Long receiver hold-off while events keep arriving, so the input backs up.
   task automatic test_backpressure();
      set_ranges(0, 39, 80, 119, 2, 20);
      idle_pct = 0;
      rx_hold = 1'b1;
      fork
         begin
            repeat (3000) @(posedge clock);
            rx_hold = 1'b0;
         end
         for (int i = 0; i < 6; i++) send_cluster_event(3, 3);
      join
      drain();
      idle_pct = 36;
   endtask

   // Random events under several settings; mostly small, a few full-size.
   task automatic test_random();
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: set_ranges(0, 39, 80, 119, 2, 20);
            1: set_ranges($urandom_range(0, 100), $urandom_range(150, 300),
                          $urandom_range(100, 200), $urandom_range(250, 511), 1, 10);
            2: set_ranges(0, 255, 256, 511, 0, 32);
            default: set_ranges(0, 20, 10, 30, 3, 8);
         endcase
         if (phase == 2) idle_pct = 0;
         for (int e = 0; e < 12; e++) begin
            if ($urandom_range(9) == 0) begin
               int n;
               n = $urandom_range(1, 6);
               for (int k = 0; k < n; k++)
                  send_hit($urandom_range(511), $urandom, k == n - 1);
            end else if ($urandom_range(15) == 0) begin
               send_cluster_event(16, 16);
            end else begin
               send_cluster_event($urandom_range(1, 5), $urandom_range(1, 5));
            end
         end
         drain();
         idle_pct = 36;
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      front_first = 0;
      front_last = 39;
      back_first = 80;
      back_last = 119;
      min_hits = 2;
      max_hits = 20;
      front_count = 0;
      back_count = 0;
      @(posedge clock);
      test_directed();
      test_config_extremes();
      test_backpressure();
      test_random();
      if (failures == 0 && expected_positions.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
`default_nettype wire
